/* hdl/ordered_array_table_macros.svh */
// ----------------------------------------------------------------------------
// Ordered array table assertion macros
// Shared concurrent assertion forms used by the table logic.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_TABLE_MACROS_SVH
`define ORDERED_ARRAY_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_array_table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_array_table assertion failed");

`endif

/* hdl/oat_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array table package
// Request codes, status codes, field widths and the cell command type.
// ----------------------------------------------------------------------------
package oat_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int FILL_W   = 5;
    localparam int CAP_W    = 5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] REQ_GET    = 3'd1;
    localparam logic [KIND_W-1:0] REQ_SET    = 3'd2;
    localparam logic [KIND_W-1:0] REQ_SEARCH = 3'd3;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] REQ_INSERT = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic                     app;
        logic                     set;
        logic                     ins;
        logic                     rem;
        logic signed [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

/* hdl/oat_cell.sv */
// ----------------------------------------------------------------------------
// Ordered array table cell
// Holds one entry and loads, shifts from a neighbor or keeps it.
// ----------------------------------------------------------------------------
module oat_cell #(
    parameter int CMP_W = 5,
    parameter int IDX   = 0
) (
    input  logic                              aclk,
    input  oat_pkg::cell_cmd_t                cmd,
    input  logic [CMP_W-1:0]                  pos,
    input  logic [CMP_W-1:0]                  count,
    input  logic signed [oat_pkg::WORD_W-1:0] lower_data,
    input  logic signed [oat_pkg::WORD_W-1:0] upper_data,
    output logic signed [oat_pkg::WORD_W-1:0] data,
    output logic                              match
);
    import oat_pkg::*;

    localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     at_pos;
    logic                     above_pos;

    assign at_pos    = (IDX_C == pos);
    assign above_pos = (IDX_C > pos);

    always_comb begin
        data_next = data_reg;
        priority if (cmd.app && (IDX_C == count)) begin
            data_next = cmd.word;
        end else if ((cmd.set || cmd.ins) && at_pos) begin
            data_next = cmd.word;
        end else if (cmd.ins && above_pos) begin
            data_next = lower_data;
        end else if (cmd.rem && (at_pos || above_pos)) begin
            data_next = upper_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == cmd.word) && (IDX_C < count);

endmodule

/* hdl/oat_first_match.sv */
// ----------------------------------------------------------------------------
// Ordered array table first match
// Finds the lowest cell whose entry matches the search word.
// ----------------------------------------------------------------------------
module oat_first_match #(
    parameter int DEPTH = oat_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = 4
) (
    input  logic [DEPTH-1:0] match,
    output logic             hit,
    output logic [IDX_W-1:0] first_idx
);
    import oat_pkg::*;

    logic [DEPTH-1:0] lowest;

    assign lowest = match & (~match + DEPTH'(1));
    assign hit    = |match;

    always_comb begin
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lowest[i]) begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

endmodule

/* hdl/ordered_array_table.sv */
// ----------------------------------------------------------------------------
// Ordered array table: each request word is answered in the cycle after it is accepted.
// One request per cycle while no answer is pending or the pending answer is taken (m_tready).
// Reset empties the table and sets the capacity limit to 16; entries are not cleared.
// ----------------------------------------------------------------------------
module ordered_array_table #(
    parameter int DEPTH = oat_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [oat_pkg::CAP_W-1:0]           cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // req_type[2:0], index[7:3], value[39:8]
    input  logic [oat_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], read_value[33:2], found_index[37:34], fill_count[42:38], zero[47:43]
    output logic [oat_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import oat_pkg::*;

    `include "ordered_array_table_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CAP_W-1:0]          cap_reg;
    logic                      m_valid_reg;
    logic [OUT_DATA_W-1:0]     m_data_reg;

    logic                      fire;
    logic [KIND_W-1:0]         in_kind;
    logic [POS_W-1:0]          in_pos;
    logic signed [WORD_W-1:0]  in_value;

    logic [CMP_W-1:0]          pos_c;
    logic [CMP_W-1:0]          cnt_c;
    logic                      pos_in_range;
    logic                      table_full;

    cell_cmd_t                 cmd;
    cell_cmd_t                 cell_cmd;
    logic signed [WORD_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]          cell_match;
    logic                      hit;
    logic [IDX_W-1:0]          first_idx;
    logic signed [WORD_W-1:0]  get_data;

    logic [STATUS_W-1:0]       status;
    logic signed [WORD_W-1:0]  read_value;
    logic [CMP_W-1:0]          found_ext;
    logic [CMP_W-1:0]          fill_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign in_kind  = s_tdata[2:0];
    assign in_pos   = s_tdata[7:3];
    assign in_value = s_tdata[39:8];

    assign pos_c        = CMP_W'(in_pos);
    assign cnt_c        = CMP_W'(count_reg);
    assign pos_in_range = (pos_c < cnt_c);
    assign table_full   = (cnt_c >= CMP_W'(cap_reg)) || (cnt_c >= CMP_W'(DEPTH));

    always_comb begin
        get_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos_c == CMP_W'(i)) begin
                get_data = get_data | cell_data[i];
            end
        end
    end

    always_comb begin
        status     = ST_OK;
        read_value = '0;
        found_ext  = '0;
        count_next = count_reg;
        cmd        = '0;
        cmd.word   = in_value;
        unique case (in_kind)
            REQ_APPEND: begin
                if (table_full) begin
                    status = ST_FULL;
                end else begin
                    cmd.app    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_GET: begin
                if (!pos_in_range) begin
                    status = ST_RANGE;
                end else begin
                    read_value = get_data;
                end
            end
            REQ_SET: begin
                if (!pos_in_range) begin
                    status = ST_RANGE;
                end else begin
                    cmd.set = 1'b1;
                end
            end
            REQ_SEARCH: begin
                if (!hit) begin
                    status = ST_NOTFOUND;
                end else begin
                    found_ext = CMP_W'(first_idx);
                end
            end
            REQ_REMOVE: begin
                if (!pos_in_range) begin
                    status = ST_RANGE;
                end else begin
                    cmd.rem    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_INSERT: begin
                if (pos_c > cnt_c) begin
                    status = ST_RANGE;
                end else if (table_full) begin
                    status = ST_FULL;
                end else begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        fill_ext = CMP_W'(count_next);
    end

    always_comb begin
        cell_cmd     = cmd;
        cell_cmd.app = cmd.app && fire;
        cell_cmd.set = cmd.set && fire;
        cell_cmd.ins = cmd.ins && fire;
        cell_cmd.rem = cmd.rem && fire;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        oat_cell #(
            .CMP_W (CMP_W),
            .IDX   (g)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .pos        (pos_c),
            .count      (cnt_c),
            .lower_data ((g == 0) ? in_value : cell_data[(g == 0) ? 0 : g - 1]),
            .upper_data (cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    oat_first_match #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_first_match (
        .match     (cell_match),
        .hit       (hit),
        .first_idx (first_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {5'd0, fill_ext[FILL_W-1:0], found_ext[FOUND_W-1:0],
                           read_value, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `OAT_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, CMP_W'(count_reg) <= CMP_W'(DEPTH))
    `OAT_ASSERT_NEXT(a_fire_loads_out, aclk, aresetn, fire, m_tvalid)
    `OAT_ASSERT_NEXT(a_grow_by_one, aclk, aresetn, fire && (cmd.app || cmd.ins), count_reg == $past(count_reg) + CNT_W'(1))
    `OAT_ASSERT_NEXT(a_shrink_by_one, aclk, aresetn, fire && cmd.rem, count_reg == $past(count_reg) - CNT_W'(1))

endmodule
